[rtl/bia_pkg.sv]
package bia_pkg;

  localparam int ID_W      = 16;
  localparam int STATUS_W  = 2;
  localparam int SUM_BITS  = 64;
  localparam int SUM_IDX_W = 6;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic                 done;
    logic [ID_W-1:0]      word;
    logic [SUM_IDX_W-1:0] offset;
  } bia_split_t;

  // Position of the lowest clear bit; the caller guarantees one exists.
  function automatic logic [SUM_IDX_W-1:0] lowest_zero(input logic [SUM_BITS-1:0] word);
    logic [SUM_IDX_W-1:0] pos;
    pos = '0;
    for (int i = SUM_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = SUM_IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

[rtl/bia_if.sv]
interface bia_req_if import bia_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [ID_W-1:0] free_id;

  modport source (output valid, output command, output free_id, input ready);
  modport sink (input valid, input command, input free_id, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink (input valid, input granted_id, input status, output ready);
endinterface

[rtl/bitmap_id_allocator_unit.sv]
// Allocate: reads and checks each summary word in turn, then the map word once a free bit is found.
// With the default size the summary holds 8 words, so an allocate scans 1 to 8 of them.
// Free: waits on the identifier split and a RAM read; an out-of-range id skips both.
// One transaction at a time; the next request is taken the cycle after the result is taken.
// After reset a clearing pass writes every map word, one per cycle,
// and no request is accepted until it completes.
module bitmap_id_allocator_unit import bia_pkg::*; #(
  parameter int ID_COUNT  = 32768,
  parameter int WORD_BITS = 64
) (
  input logic       clk,
  input logic       rst,
  bia_req_if.sink   req,
  bia_rsp_if.source rsp
);

  localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_COUNT  = (WORD_COUNT + SUM_BITS - 1) / SUM_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SUM_AW     = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
  localparam int IDX_W1     = $clog2(ID_COUNT) + 1;
  localparam int CW         = (IDX_W1 > ID_W) ? IDX_W1 : ID_W + 1;
  localparam int LAST_BITS  = ID_COUNT - (WORD_COUNT - 1) * WORD_BITS;
  localparam int SUM_LAST   = WORD_COUNT - (SUM_COUNT - 1) * SUM_BITS;

  localparam logic [WORD_BITS-1:0] DATA_PAD =
    ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
  localparam logic [SUM_BITS-1:0] SUM_PAD =
    ~((SUM_BITS'(1) << SUM_LAST) - SUM_BITS'(1));
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(WORD_COUNT - 1);
  localparam logic [SUM_AW-1:0] LAST_SUM  = SUM_AW'(SUM_COUNT - 1);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_A_SRD   = 4'd2;
  localparam logic [3:0] ST_A_SCHK  = 4'd3;
  localparam logic [3:0] ST_A_DRD   = 4'd4;
  localparam logic [3:0] ST_A_DCHK  = 4'd5;
  localparam logic [3:0] ST_F_SPLIT = 4'd6;
  localparam logic [3:0] ST_F_DRD   = 4'd7;
  localparam logic [3:0] ST_F_DCHK  = 4'd8;
  localparam logic [3:0] ST_OUT     = 4'd9;

  logic [3:0]           state;
  logic [WA_W-1:0]      clr_cnt;
  logic [SUM_AW-1:0]    sidx;
  logic [SUM_IDX_W-1:0] sbit;
  logic [WA_W-1:0]      widx;
  logic [SUM_IDX_W-1:0] off;
  logic [SUM_BITS-1:0]  sum_saved;
  logic [IDX_W1-1:0]    base;
  logic                 rsp_valid;
  logic [ID_W-1:0]      granted;
  logic [STATUS_W-1:0]  status_r;

  logic                 data_we;
  logic [WA_W-1:0]      data_waddr;
  logic [WORD_BITS-1:0] data_wdata;
  logic [WORD_BITS-1:0] data_rdata;
  logic                 sum_we;
  logic [SUM_AW-1:0]    sum_waddr;
  logic [SUM_BITS-1:0]  sum_wdata;
  logic [SUM_BITS-1:0]  sum_rdata;

  logic [SUM_BITS-1:0]  sum_view;
  logic                 sum_all_full;
  logic [SUM_IDX_W-1:0] sum_zero;
  logic [WORD_BITS-1:0] data_view;
  logic [SUM_BITS-1:0]  data_ext;
  logic [SUM_IDX_W-1:0] data_zero;
  logic [WORD_BITS-1:0] alloc_mask;
  logic [WORD_BITS-1:0] free_mask;
  logic [SUM_BITS-1:0]  sbit_mask;
  logic                 free_hit;
  logic                 id_bad;
  logic                 split_start;
  bia_split_t           split;

  bia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .raddr(widx),
    .rdata(data_rdata)
  );

  bia_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(SUM_COUNT)
  ) u_sum_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .raddr(sidx),
    .rdata(sum_rdata)
  );

  bia_id_split #(
    .WORD_BITS(WORD_BITS)
  ) u_split (
    .clk  (clk),
    .rst  (rst),
    .start(split_start),
    .id   (req.free_id),
    .res  (split)
  );

  // Bits past the last identifier always read as used.
  always_comb begin
    sum_view     = sum_rdata | ((sidx == LAST_SUM) ? SUM_PAD : '0);
    sum_all_full = &sum_view;
    sum_zero     = lowest_zero(sum_view);
    data_view    = data_rdata | ((widx == LAST_WORD) ? DATA_PAD : '0);
    data_ext     = '1;
    data_ext[WORD_BITS-1:0] = data_view;
    data_zero    = lowest_zero(data_ext);
    alloc_mask   = WORD_BITS'(1) << data_zero;
    free_mask    = WORD_BITS'(1) << off;
    sbit_mask    = SUM_BITS'(1) << sbit;
    free_hit     = |(data_rdata & free_mask);
    id_bad       = (req.free_id == '0) || (CW'(req.free_id) > CW'(ID_COUNT));
    split_start  = (state == ST_IDLE) && req.valid && (req.command == CMD_FREE) && !id_bad;
  end

  always_comb begin
    data_we    = 1'b0;
    data_waddr = widx;
    data_wdata = data_rdata;
    sum_we     = 1'b0;
    sum_waddr  = sidx;
    sum_wdata  = sum_rdata;
    unique case (state)
      ST_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_cnt;
        data_wdata = '0;
        sum_we     = (WA_W + 1)'(clr_cnt) < (WA_W + 1)'(SUM_COUNT);
        sum_waddr  = SUM_AW'(clr_cnt);
        sum_wdata  = '0;
      end
      ST_A_DCHK: begin
        data_we    = 1'b1;
        data_wdata = data_rdata | alloc_mask;
        sum_we     = &(data_view | alloc_mask);
        sum_wdata  = sum_saved | sbit_mask;
      end
      ST_F_DCHK: begin
        data_we    = free_hit;
        data_wdata = data_rdata & ~free_mask;
        sum_we     = free_hit;
        sum_wdata  = sum_rdata & ~sbit_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + WA_W'(1);
          if (clr_cnt == LAST_WORD) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            if (req.command == CMD_ALLOC) begin
              sidx  <= '0;
              state <= ST_A_SRD;
            end else if (id_bad) begin
              granted   <= '0;
              status_r  <= STATUS_BAD_FREE;
              rsp_valid <= 1'b1;
              state     <= ST_OUT;
            end else begin
              state <= ST_F_SPLIT;
            end
          end
        end
        ST_A_SRD: begin
          state <= ST_A_SCHK;
        end
        ST_A_SCHK: begin
          if (!sum_all_full) begin
            sbit      <= sum_zero;
            sum_saved <= sum_rdata;
            widx      <= WA_W'({sidx, sum_zero});
            state     <= ST_A_DRD;
          end else if (sidx == LAST_SUM) begin
            granted   <= '0;
            status_r  <= STATUS_FULL;
            rsp_valid <= 1'b1;
            state     <= ST_OUT;
          end else begin
            sidx  <= sidx + SUM_AW'(1);
            state <= ST_A_SRD;
          end
        end
        ST_A_DRD: begin
          base  <= IDX_W1'(widx * IDX_W1'(WORD_BITS));
          state <= ST_A_DCHK;
        end
        ST_A_DCHK: begin
          granted   <= ID_W'(base + IDX_W1'(data_zero) + IDX_W1'(1));
          status_r  <= STATUS_OK;
          rsp_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_F_SPLIT: begin
          if (split.done) begin
            widx  <= WA_W'(split.word);
            off   <= split.offset;
            sidx  <= SUM_AW'(split.word >> SUM_IDX_W);
            sbit  <= SUM_IDX_W'(split.word);
            state <= ST_F_DRD;
          end
        end
        ST_F_DRD: begin
          state <= ST_F_DCHK;
        end
        ST_F_DCHK: begin
          granted   <= '0;
          status_r  <= free_hit ? STATUS_OK : STATUS_BAD_FREE;
          rsp_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.granted_id = granted;
  assign rsp.status     = status_r;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("Request accepted while a result is pending.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.granted_id) && $stable(rsp.status)))
    else $error("Result changed while waiting for its transaction.");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.granted_id == '0))
    else $error("Identifier returned with an error status.");

  a_split_in_wait: assert property (@(posedge clk) disable iff (rst)
    split.done |-> (state == ST_F_SPLIT))
    else $error("Identifier split finished outside its wait state.");
`endif

endmodule

[rtl/bia_ram.sv]
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bia_id_split.sv]
module bia_id_split import bia_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [ID_W-1:0] id,
  output bia_split_t      res
);

  localparam int    LOG_WB = $clog2(WORD_BITS);
  localparam int    SHIFT  = ID_W + LOG_WB;
  localparam longint MULT  = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int    MULT_W = ID_W + 1;
  localparam int    PROD_W = ID_W + MULT_W;

  logic [2:0]           vld;
  logic [ID_W-1:0]      idx1;
  logic [PROD_W-1:0]    prod1;
  logic [ID_W-1:0]      idx2;
  logic [ID_W-1:0]      quot2;
  logic [ID_W-1:0]      word3;
  logic [SUM_IDX_W-1:0] offset3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  // The quotient comes from a multiply by a rounded-up reciprocal, exact for 16-bit indices.
  always_ff @(posedge clk) begin
    idx1    <= ID_W'(id - ID_W'(1));
    prod1   <= PROD_W'(ID_W'(id - ID_W'(1))) * PROD_W'(MULT);
    idx2    <= idx1;
    quot2   <= ID_W'(prod1 >> SHIFT);
    word3   <= quot2;
    offset3 <= SUM_IDX_W'(idx2 - ID_W'(quot2 * ID_W'(WORD_BITS)));
  end

  always_comb begin
    res.done   = vld[2];
    res.word   = word3;
    res.offset = offset3;
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bia_pkg::*;

  localparam int ID_COUNT     = 32768;
  localparam int WORD_BITS    = 64;
  localparam int WORD_COUNT   = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 300;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } grant_t;

  class id_map_scoreboard;
    bit [WORD_BITS-1:0] used_map [WORD_COUNT];
    int                 live_ids [$];
    grant_t             expected_grants [$];
    int                 errors;

    function void clear_map();
      foreach (used_map[w]) used_map[w] = '0;
      live_ids.delete();
      expected_grants.delete();
      errors = 0;
    endfunction

    function void note_request(input logic cmd, input logic [ID_W-1:0] id);
      grant_t g;
      bit     found;
      int     idx;
      int     pos;
      g.granted_id = '0;
      found = 1'b0;
      if (cmd == CMD_ALLOC) begin
        g.status = STATUS_FULL;
        for (int w = 0; w < WORD_COUNT; w++) begin
          if (!found && used_map[w] != {WORD_BITS{1'b1}}) begin
            for (int b = 0; b < WORD_BITS; b++) begin
              if (!found && !used_map[w][b] && (w * WORD_BITS + b) < ID_COUNT) begin
                found = 1'b1;
                used_map[w][b] = 1'b1;
                g.granted_id = ID_W'(w * WORD_BITS + b + 1);
                g.status = STATUS_OK;
                live_ids.push_back(w * WORD_BITS + b + 1);
              end
            end
          end
        end
      end else begin
        g.status = STATUS_BAD_FREE;
        if (id != 0 && int'(id) <= ID_COUNT) begin
          idx = int'(id) - 1;
          if (used_map[idx / WORD_BITS][idx % WORD_BITS]) begin
            used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
            g.status = STATUS_OK;
            pos = -1;
            foreach (live_ids[i]) if (live_ids[i] == int'(id)) pos = i;
            if (pos >= 0) live_ids.delete(pos);
          end
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void check_grant(input logic [ID_W-1:0] id, input logic [STATUS_W-1:0] st);
      grant_t g;
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected response granted_id=%0d status=%0d", id, st);
      end else begin
        g = expected_grants.pop_front();
        if (id !== g.granted_id || st !== g.status) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: granted_id exp %0d got %0d, status exp %0d got %0d",
                     g.granted_id, id, g.status, st);
        end
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function int live_count();
      return live_ids.size();
    endfunction

    function int pick_live();
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   hold_left;
  int   idle_cycles;

  id_map_scoreboard sb;

  bia_req_if req_if ();
  bia_rsp_if rsp_if ();

  bitmap_id_allocator_unit #(
    .ID_COUNT (ID_COUNT),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic issue_request(input logic cmd, input logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.free_id <= id;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(cmd, id);
  endtask

  task automatic send_random_request();
    int r;
    int pick;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      issue_request(CMD_ALLOC, ID_W'($urandom_range(0, 65535)));
    end else if (r < 85 && sb.live_count() > 0) begin
      issue_request(CMD_FREE, ID_W'(sb.pick_live()));
    end else if (r < 90) begin
      issue_request(CMD_FREE, ID_W'($urandom_range(0, 65535)));
    end else if (r < 95) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: issue_request(CMD_FREE, ID_W'(0));
        1: issue_request(CMD_FREE, ID_W'(ID_COUNT));
        2: issue_request(CMD_FREE, ID_W'(ID_COUNT + 1));
        default: issue_request(CMD_FREE, {ID_W{1'b1}});
      endcase
    end else begin
      issue_request(CMD_FREE, ID_W'($urandom_range(1, ID_COUNT)));
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) sb.check_grant(rsp_if.granted_id, rsp_if.status);
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear_map();
    snd_idle_pct = 17;
    rcv_idle_pct = 61;
    hold_left    = 0;
    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_ALLOC;
    req_if.free_id <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_ALLOC, {ID_W{1'b1}});
    issue_request(CMD_ALLOC, ID_W'(16'h5a5a));
    issue_request(CMD_FREE, ID_W'(0));
    issue_request(CMD_FREE, ID_W'(ID_COUNT + 1));
    issue_request(CMD_FREE, {ID_W{1'b1}});
    issue_request(CMD_FREE, ID_W'(ID_COUNT));
    issue_request(CMD_FREE, ID_W'(2));
    issue_request(CMD_FREE, ID_W'(2));
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_FREE, ID_W'(4));
    issue_request(CMD_FREE, ID_W'(1));
    issue_request(CMD_FREE, ID_W'(3));
    issue_request(CMD_ALLOC, '0);

    repeat (PHASE_ITEMS) send_random_request();

    snd_idle_pct = 61;
    rcv_idle_pct = 17;
    hold_left    = HOLD_CYCLES;
    repeat (PHASE_ITEMS) send_random_request();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;

    // Exercise allocation and release at the edges of the identifier range.
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_ALLOC, {ID_W{1'b1}});
    issue_request(CMD_FREE, ID_W'(ID_COUNT));
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_FREE, ID_W'(1));
    issue_request(CMD_FREE, ID_W'(1));
    issue_request(CMD_ALLOC, '0);
    issue_request(CMD_FREE, ID_W'(0));
    issue_request(CMD_FREE, ID_W'(ID_COUNT + 1));
    issue_request(CMD_ALLOC, '0);

    repeat (PHASE_ITEMS) send_random_request();
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
